@@ rtl/core/rm_pkg.sv @@
package rm_pkg;

  // Fixed field widths
  localparam int SampleW = 16;
  localparam int CfgIndexW = 2;
  localparam int CfgDataW = 32;

  // Queue between front and back
  localparam int QueueDepth = 4;
  localparam int QueuePtrW = $clog2(QueueDepth);

  // 2*pi in Q30, used when the sine table is built
  localparam logic [63:0] TwoPiQ30 = 64'd6746518852;

  // Register map
  typedef enum logic [CfgIndexW-1:0] {
    REG_ENABLE        = 2'd0,
    REG_PHASE_STEP    = 2'd1,
    REG_OUTPUT_OFFSET = 2'd2
  } cfg_reg_t;

  // One request in flight between front and back
  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic signed [SampleW-1:0] sine;
    logic                      modulate;
  } rm_item_t;

  // Queue occupancy flags
  typedef struct packed {
    logic full;
    logic empty;
  } rm_q_status_t;

endpackage

@@ rtl/core/rm_front.sv @@
module rm_front #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          enable,
  input  logic [PHASE_BITS-1:0]         phase_step,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [15:0]            in_sample,
  output logic                          push,
  output rm_pkg::rm_item_t              push_item,
  input  rm_pkg::rm_q_status_t          q_status
);
  import rm_pkg::*;

  localparam int TableBits = $clog2(SINE_TABLE_DEPTH);

  // sin(2*pi*r/depth) in Q15 for the first quadrant, Taylor series in Q30
  function automatic logic [15:0] quarter_sine(input logic [63:0] r, input int tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] q;
    x = (r * TwoPiQ30) >> tbits;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum = sum - term;
    q = (sum + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[15:0];
  endfunction

  // Full-wave entry built from the first quadrant by symmetry
  function automatic logic [15:0] sine_entry(input int k, input int tbits);
    logic [63:0] quarter;
    logic [63:0] kk;
    logic [63:0] r;
    logic [1:0]  quad;
    logic [15:0] v;
    quarter = 64'd1 << (tbits - 2);
    kk = 64'(k);
    quad = 2'((kk >> (tbits - 2)) & 64'd3);
    r = kk & (quarter - 64'd1);
    case (quad)
      2'd0: v = quarter_sine(r, tbits);
      2'd1: v = quarter_sine(quarter - r, tbits);
      2'd2: v = ~quarter_sine(r, tbits) + 16'd1;
      default: v = ~quarter_sine(quarter - r, tbits) + 16'd1;
    endcase
    return v;
  endfunction

  logic [PHASE_BITS-1:0]   phase;
  logic [PHASE_BITS-1:0]   phase_next;
  logic [TableBits-1:0]    sine_idx;
  logic                    in_fire;
  logic                    f_valid;
  logic signed [15:0]      f_sample;
  logic                    f_modulate;
  logic signed [15:0]      sine_q;
  logic signed [15:0]      sine_rom [SINE_TABLE_DEPTH];

  // Sine ROM, contents fixed at elaboration
  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [15:0] Entry = sine_entry(k, TableBits);
    assign sine_rom[k] = $signed(Entry);
  end

  // Handshake: the stage register frees when the queue takes its request
  assign push     = f_valid && !q_status.full;
  assign in_ready = !f_valid || !q_status.full;
  assign in_fire  = in_valid && in_ready;

  // Phase advance and table index from the top phase bits
  assign phase_next = phase + phase_step;
  assign sine_idx   = phase_next[PHASE_BITS-1 -: TableBits];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (in_fire && enable) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_fire) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  // Registered table read alongside the sample
  always_ff @(posedge clk) begin
    if (in_fire) begin
      f_sample   <= in_sample;
      f_modulate <= enable;
      sine_q     <= sine_rom[sine_idx];
    end
  end

  assign push_item.sample   = f_sample;
  assign push_item.sine     = sine_q;
  assign push_item.modulate = f_modulate;

`ifndef ASSERT_OFF
  // Phase only moves on an accepted request while modulating
  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !(in_fire && enable) |=> phase == $past(phase))
    else $error("carrier phase moved without a modulated request");
`endif

endmodule

@@ rtl/core/rm_queue.sv @@
module rm_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  rm_pkg::rm_item_t     push_item,
  input  logic                 pop,
  output rm_pkg::rm_item_t     pop_item,
  output rm_pkg::rm_q_status_t status
);
  import rm_pkg::*;

  localparam int CountW = $clog2(QueueDepth + 1);

  rm_item_t               slots [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr;
  logic [QueuePtrW-1:0]   rd_ptr;
  logic [CountW-1:0]      count;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  assign pop_item = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign status.full  = (count == CountW'(QueueDepth));
  assign status.empty = (count == '0);

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && status.empty))
    else $error("pop from an empty queue");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("fill count did not follow a lone push");
`endif

endmodule

@@ rtl/core/rm_back.sv @@
module rm_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic signed [15:0]   output_offset,
  input  rm_pkg::rm_q_status_t q_status,
  input  rm_pkg::rm_item_t     pop_item,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_sample
);
  import rm_pkg::*;

  logic                 out_load;
  logic                 p_ready;
  logic                 p_valid;
  logic signed [31:0]   p_prod;
  logic signed [15:0]   p_sample;
  logic                 p_modulate;
  logic signed [31:0]   biased;
  logic signed [16:0]   scaled;
  logic signed [17:0]   sum;
  logic signed [15:0]   sat;

  // Stage advance
  assign out_load = !out_valid || out_ready;
  assign p_ready  = !p_valid || out_load;
  assign pop      = !q_status.empty && p_ready;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_ready) begin
      p_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p_prod     <= pop_item.sample * pop_item.sine;
      p_sample   <= pop_item.sample;
      p_modulate <= pop_item.modulate;
    end
  end

  // Q30 to Q15 truncating toward zero (or the bare sample when not modulating), add offset, saturate
  assign biased = p_prod + (p_prod[31] ? 32'sd32767 : 32'sd0);
  assign scaled = p_modulate ? biased[31:15] : {p_sample[15], p_sample};
  assign sum    = {scaled[16], scaled} + {{2{output_offset[15]}}, output_offset};

  always_comb begin
    if (sum > 18'sd32767) begin
      sat = 16'sh7fff;
    end else if (sum < -18'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[15:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && p_valid) begin
      out_sample <= sat;
    end
  end

`ifndef ASSERT_OFF
  // A result waiting at the port is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_sample == $past(out_sample))
    else $error("stalled result overwritten");
`endif

endmodule

@@ rtl/core/ring_modulator_core.sv @@
// Ring modulator with a sine carrier from a phase accumulator. Each accepted
// sample either is multiplied by sin(phase) (Q1.15, truncated toward zero)
// after the phase advances by phase_step, or passes straight through when
// enable is 0; output_offset is then added and the result saturates to 16
// bits. The block takes one sample per clock cycle when the output side keeps
// up; each sample passes through registers after the phase add and sine ROM
// read, the queue, the multiply, and the offset and saturate. The sine table holds
// SINE_TABLE_DEPTH entries, fixed when the design is elaborated, and is
// indexed by the top phase bits. A four-entry queue between the front and
// back halves absorbs stalls on either side. Write configuration only while
// no sample is in flight.
module ring_modulator_core #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  // input sample stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // [15:0] sample_in
  // output sample stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,  // [15:0] sample_out
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rm_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [rm_pkg::CfgDataW-1:0]   cfg_data
);
  import rm_pkg::*;

  logic                   enable;
  logic [PHASE_BITS-1:0]  phase_step;
  logic signed [15:0]     output_offset;
  logic                   push;
  rm_item_t               push_item;
  logic                   pop;
  rm_item_t               pop_item;
  rm_q_status_t           q_status;
  logic signed [15:0]     out_sample;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      phase_step    <= '0;
      output_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_ENABLE:        enable        <= cfg_data[0];
        REG_PHASE_STEP:    phase_step    <= cfg_data[PHASE_BITS-1:0];
        REG_OUTPUT_OFFSET: output_offset <= $signed(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  rm_front #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .enable     (enable),
    .phase_step (phase_step),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_sample  ($signed(s_axis_tdata)),
    .push       (push),
    .push_item  (push_item),
    .q_status   (q_status)
  );

  rm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  rm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .output_offset (output_offset),
    .q_status      (q_status),
    .pop_item      (pop_item),
    .pop           (pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_sample    (out_sample)
  );

  assign m_axis_tdata = out_sample;

endmodule
